// ===== hdl/ttw_pkg.sv =====
// shared types, constants and the clock step function for the tick timer
`default_nettype none
package ttw_pkg;

  // input opcodes
  localparam logic [2:0] OP_DELAY    = 3'd0;
  localparam logic [2:0] OP_TICK     = 3'd1;
  localparam logic [2:0] OP_GET_UP   = 3'd2;
  localparam logic [2:0] OP_GET_WALL = 3'd3;
  localparam logic [2:0] OP_SET_WALL = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_REPLY   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  localparam logic [7:0] TPS_RESET    = 8'd30;
  localparam logic [6:0] SEC_LIMIT    = 7'd60;
  localparam logic [6:0] MIN_LIMIT    = 7'd60;
  localparam logic [5:0] HOUR_LIMIT   = 6'd24;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  typedef enum logic [2:0] {
    CL_DELAY_ZERO,
    CL_DELAY,
    CL_TICK,
    CL_GET_UP,
    CL_GET_WALL,
    CL_SET_WALL,
    CL_OTHER
  } cmd_class_t;

  typedef struct packed {
    cmd_class_t  cls;
    logic [7:0]  client;
    logic [14:0] delay;
    hms_t        set_time;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] client;
    hms_t       t;
    logic       last;
  } result_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } back_state_t;

  function automatic hms_t hms_step(input hms_t t);
    hms_t       o;
    logic [6:0] s1;
    logic [6:0] m1;
    logic [5:0] h1;
    o  = t;
    s1 = {1'b0, t.second} + 7'd1;
    m1 = {1'b0, t.minute} + 7'd1;
    h1 = {1'b0, t.hour} + 6'd1;
    if (s1 < SEC_LIMIT) begin
      o.second = s1[5:0];
    end else begin
      o.second = '0;
      if (m1 < MIN_LIMIT) begin
        o.minute = m1[5:0];
      end else begin
        o.minute = '0;
        if (h1 < HOUR_LIMIT) begin
          o.hour = h1[4:0];
        end else begin
          o.hour = '0;
        end
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tick_timer_with_delay_waits_core.sv =====
// top level of the tick timer with delay wait table, uptime clock and wall clock
//
// commands enter on the in_ channel (valid/ready) and results leave on the
// out_ channel (valid/ready); out_last marks the final result of a command.
// a front register classifies each item and pushes it into a two-entry
// command queue; the back stage executes one command at a time.
// get, set, zero delay, unknown and rejected delays give one result; a
// parked delay gives none. a tick walks the wait table one slot a cycle
// while no release waits on a stalled receiver, emitting a release for each
// expired slot, then the acknowledge; the back stage takes no command
// until the acknowledge is loaded. a single result passes the front register,
// the command queue and the output register; the first result of a tick
// also passes through the walk state.
// results wait in a single output register; while the receiver stalls the
// back stage holds at the next result it must give, the queue fills and in_ready then falls.
// cfg_we writes ticks_per_second at once; write it only while idle.
// synchronous reset empties the table and queue, zeroes both clocks and the
// prescaler and sets ticks_per_second to 30.
`default_nettype none
module tick_timer_with_delay_waits_core #(
  parameter int WAIT_SLOTS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [7:0]   cfg_wdata,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [2:0]   in_opcode,
  input  wire logic [7:0]   in_client_id,
  input  wire logic [14:0]  in_delay_ticks,
  input  wire logic [4:0]   in_set_hour,
  input  wire logic [5:0]   in_set_minute,
  input  wire logic [5:0]   in_set_second,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_target_client,
  output logic [4:0]        out_hour,
  output logic [5:0]        out_minute,
  output logic [5:0]        out_second,
  output logic              out_last
);

  ttw_pkg::cmd_t    f_cmd, q_cmd;
  logic             f_valid, f_ready;
  logic             q_valid, q_ready;
  ttw_pkg::result_t res;

  ttw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_client_id   (in_client_id),
    .in_delay_ticks (in_delay_ticks),
    .in_set_hour    (in_set_hour),
    .in_set_minute  (in_set_minute),
    .in_set_second  (in_set_second),
    .cmd            (f_cmd),
    .cmd_valid      (f_valid),
    .cmd_ready      (f_ready)
  );

  ttw_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (f_cmd),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_cmd    (q_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  ttw_back #(
    .WAIT_SLOTS (WAIT_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .res       (res),
    .res_valid (out_valid),
    .res_ready (out_ready)
  );

  assign out_kind          = res.kind;
  assign out_target_client = res.client;
  assign out_hour          = res.t.hour;
  assign out_minute        = res.t.minute;
  assign out_second        = res.t.second;
  assign out_last          = res.last;

endmodule
`default_nettype wire

// ===== hdl/ttw_front.sv =====
// front stage: accepts input items and classifies them into commands
`default_nettype none
module ttw_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    in_opcode,
  input  wire logic [7:0]    in_client_id,
  input  wire logic [14:0]   in_delay_ticks,
  input  wire logic [4:0]    in_set_hour,
  input  wire logic [5:0]    in_set_minute,
  input  wire logic [5:0]    in_set_second,
  output ttw_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready
);

  ttw_pkg::cmd_t cmd_r, cmd_nxt;
  logic          vld_r, vld_nxt;
  logic          take;

  assign in_ready  = !vld_r || cmd_ready;
  assign take      = in_valid && in_ready;
  assign cmd       = cmd_r;
  assign cmd_valid = vld_r;

  always_comb begin
    cmd_nxt = cmd_r;
    vld_nxt = vld_r && !cmd_ready;
    if (take) begin
      vld_nxt                 = 1'b1;
      cmd_nxt.client          = in_client_id;
      cmd_nxt.delay           = in_delay_ticks;
      cmd_nxt.set_time.hour   = in_set_hour;
      cmd_nxt.set_time.minute = in_set_minute;
      cmd_nxt.set_time.second = in_set_second;
      case (in_opcode)
        ttw_pkg::OP_DELAY: begin
          cmd_nxt.cls = (in_delay_ticks == '0) ? ttw_pkg::CL_DELAY_ZERO : ttw_pkg::CL_DELAY;
        end
        ttw_pkg::OP_TICK:     cmd_nxt.cls = ttw_pkg::CL_TICK;
        ttw_pkg::OP_GET_UP:   cmd_nxt.cls = ttw_pkg::CL_GET_UP;
        ttw_pkg::OP_GET_WALL: cmd_nxt.cls = ttw_pkg::CL_GET_WALL;
        ttw_pkg::OP_SET_WALL: cmd_nxt.cls = ttw_pkg::CL_SET_WALL;
        default:              cmd_nxt.cls = ttw_pkg::CL_OTHER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/ttw_cmd_fifo.sv =====
// short command queue between the front and back stages
`default_nettype none
module ttw_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ttw_pkg::cmd_t push_cmd,
  input  wire logic          push_valid,
  output logic               push_ready,
  output ttw_pkg::cmd_t      pop_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready
);

  localparam int CNT_W = ttw_pkg::QPTR_W + 1;

  ttw_pkg::cmd_t                mem_r [ttw_pkg::QDEPTH];
  logic [ttw_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [ttw_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         push, pop;

  assign push_ready = (cnt_r != CNT_W'(ttw_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ttw_back.sv =====
// back stage: clocks, prescaler, wait table walk and result register
`default_nettype none
module ttw_back #(
  parameter int WAIT_SLOTS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_wdata,
  input  wire ttw_pkg::cmd_t cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  output ttw_pkg::result_t   res,
  output logic               res_valid,
  input  wire logic          res_ready
);

  localparam int IW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam int CW = $clog2(WAIT_SLOTS + 1);

  ttw_pkg::back_state_t state_r, state_nxt;
  logic [7:0]           tps_r, tps_nxt;
  logic [7:0]           pre_r, pre_nxt;
  ttw_pkg::hms_t        up_r, up_nxt;
  ttw_pkg::hms_t        wall_r, wall_nxt;
  logic [7:0]           cli_r [WAIT_SLOTS];
  logic [7:0]           cli_nxt [WAIT_SLOTS];
  logic [14:0]          rem_r [WAIT_SLOTS];
  logic [14:0]          rem_nxt [WAIT_SLOTS];
  logic [CW-1:0]        wcnt_r, wcnt_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [CW-1:0]        keep_r, keep_nxt;
  logic [7:0]           tclient_r, tclient_nxt;
  ttw_pkg::result_t     out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 load;
  logic [8:0]           pre_inc;
  logic [14:0]          head_dec;
  logic [CW-1:0]        waddr;
  ttw_pkg::result_t     emit_res;
  logic                 emit;

  assign load      = !out_valid_r || res_ready;
  assign res       = out_r;
  assign res_valid = out_valid_r;
  assign pre_inc   = {1'b0, pre_r} + 9'd1;
  assign head_dec  = rem_r[0] - {14'd0, (rem_r[0] != '0)};
  // survivors pile up behind the entries not yet walked
  assign waddr     = wcnt_r - CW'(1) - k_r + keep_r;

  always_comb begin
    state_nxt   = state_r;
    tps_nxt     = cfg_we ? cfg_wdata : tps_r;
    pre_nxt     = pre_r;
    up_nxt      = up_r;
    wall_nxt    = wall_r;
    cli_nxt     = cli_r;
    rem_nxt     = rem_r;
    wcnt_nxt    = wcnt_r;
    k_nxt       = k_r;
    keep_nxt    = keep_r;
    tclient_nxt = tclient_r;
    cmd_ready   = 1'b0;
    emit        = 1'b0;
    emit_res    = '0;
    emit_res.last = 1'b1;
    emit_res.kind = ttw_pkg::KIND_REPLY;

    case (state_r)
      ttw_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          emit_res.client = cmd.client;
          case (cmd.cls)
            ttw_pkg::CL_DELAY: begin
              if (wcnt_r < CW'(WAIT_SLOTS)) begin
                cmd_ready                 = 1'b1;
                cli_nxt[wcnt_r[IW-1:0]]   = cmd.client;
                rem_nxt[wcnt_r[IW-1:0]]   = cmd.delay;
                wcnt_nxt                  = wcnt_r + CW'(1);
              end else if (load) begin
                cmd_ready     = 1'b1;
                emit          = 1'b1;
                emit_res.kind = ttw_pkg::KIND_REJECT;
              end
            end
            ttw_pkg::CL_TICK: begin
              cmd_ready   = 1'b1;
              tclient_nxt = cmd.client;
              k_nxt       = '0;
              keep_nxt    = '0;
              state_nxt   = ttw_pkg::BK_WALK;
              if (pre_inc >= {1'b0, tps_r}) begin
                pre_nxt  = '0;
                up_nxt   = ttw_pkg::hms_step(up_r);
                wall_nxt = ttw_pkg::hms_step(wall_r);
              end else begin
                pre_nxt = pre_inc[7:0];
              end
            end
            ttw_pkg::CL_GET_UP: begin
              if (load) begin
                cmd_ready  = 1'b1;
                emit       = 1'b1;
                emit_res.t = up_r;
              end
            end
            ttw_pkg::CL_GET_WALL: begin
              if (load) begin
                cmd_ready  = 1'b1;
                emit       = 1'b1;
                emit_res.t = wall_r;
              end
            end
            ttw_pkg::CL_SET_WALL: begin
              if (load) begin
                cmd_ready  = 1'b1;
                emit       = 1'b1;
                wall_nxt   = cmd.set_time;
                emit_res.t = cmd.set_time;
              end
            end
            default: begin
              if (load) begin
                cmd_ready = 1'b1;
                emit      = 1'b1;
              end
            end
          endcase
        end
      end
      ttw_pkg::BK_WALK: begin
        if (k_r == wcnt_r) begin
          // every slot walked: acknowledge the tick
          if (load) begin
            emit            = 1'b1;
            emit_res.client = tclient_r;
            wcnt_nxt        = keep_r;
            state_nxt       = ttw_pkg::BK_IDLE;
          end
        end else if (head_dec == '0) begin
          if (load) begin
            emit            = 1'b1;
            emit_res.kind   = ttw_pkg::KIND_RELEASE;
            emit_res.client = cli_r[0];
            emit_res.last   = 1'b0;
            for (int j = 0; j < WAIT_SLOTS - 1; j++) begin
              cli_nxt[j] = cli_r[j+1];
              rem_nxt[j] = rem_r[j+1];
            end
            k_nxt = k_r + CW'(1);
          end
        end else begin
          for (int j = 0; j < WAIT_SLOTS - 1; j++) begin
            cli_nxt[j] = cli_r[j+1];
            rem_nxt[j] = rem_r[j+1];
          end
          cli_nxt[waddr[IW-1:0]] = cli_r[0];
          rem_nxt[waddr[IW-1:0]] = head_dec;
          keep_nxt = keep_r + CW'(1);
          k_nxt    = k_r + CW'(1);
        end
      end
      default: begin
        state_nxt = ttw_pkg::BK_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && !res_ready;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttw_pkg::BK_IDLE;
      tps_r       <= ttw_pkg::TPS_RESET;
      pre_r       <= '0;
      up_r        <= '0;
      wall_r      <= '0;
      wcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tps_r       <= tps_nxt;
      pre_r       <= pre_nxt;
      up_r        <= up_nxt;
      wall_r      <= wall_nxt;
      wcnt_r      <= wcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cli_r     <= cli_nxt;
    rem_r     <= rem_nxt;
    k_r       <= k_nxt;
    keep_r    <= keep_nxt;
    tclient_r <= tclient_nxt;
    out_r     <= out_nxt;
  end

  a_wcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wcnt_r <= CW'(WAIT_SLOTS))
    else $error("wait table count beyond slot count");

  a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ttw_pkg::BK_WALK) |-> (k_r <= wcnt_r) && (keep_r <= k_r))
    else $error("walk index out of range");

  a_no_pop_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ttw_pkg::BK_WALK) |-> !cmd_ready)
    else $error("command taken during a tick walk");

  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ttw_pkg::BK_WALK && state_nxt == ttw_pkg::BK_IDLE)
      |=> out_valid_r && out_r.last)
    else $error("tick walk ended without a final acknowledge");

endmodule
`default_nettype wire
